// ===== rtl/rne_pkg.sv =====
// Package for the Roman numeral encoder: widths, register indexes, letter codes,
// the numeral symbol table and the command and status types shared by the modules.
// Depends on nothing.
package rne_pkg;

  localparam int YEAR_W      = 12;
  localparam int LETTER_W    = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int NUM_SYMS    = 13;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST  = 12'd1000;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST  = 12'd3000;
  localparam logic [YEAR_W-1:0] HARD_MAX_YEAR = 12'd3999;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 1'b1;

  localparam logic [LETTER_W-1:0] CHR_NONE = 8'h00;
  localparam logic [LETTER_W-1:0] CHR_M    = 8'h4D;
  localparam logic [LETTER_W-1:0] CHR_D    = 8'h44;
  localparam logic [LETTER_W-1:0] CHR_C    = 8'h43;
  localparam logic [LETTER_W-1:0] CHR_L    = 8'h4C;
  localparam logic [LETTER_W-1:0] CHR_X    = 8'h58;
  localparam logic [LETTER_W-1:0] CHR_V    = 8'h56;
  localparam logic [LETTER_W-1:0] CHR_I    = 8'h49;

  typedef struct packed {
    logic [YEAR_W-1:0]   value;
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
    logic                pair;
  } sym_t;

  // Symbols in ascending order of value.
  localparam sym_t SYM_TABLE [NUM_SYMS] = '{
    '{12'd1,    CHR_I, CHR_NONE, 1'b0},
    '{12'd4,    CHR_I, CHR_V,    1'b1},
    '{12'd5,    CHR_V, CHR_NONE, 1'b0},
    '{12'd9,    CHR_I, CHR_X,    1'b1},
    '{12'd10,   CHR_X, CHR_NONE, 1'b0},
    '{12'd40,   CHR_X, CHR_L,    1'b1},
    '{12'd50,   CHR_L, CHR_NONE, 1'b0},
    '{12'd90,   CHR_X, CHR_C,    1'b1},
    '{12'd100,  CHR_C, CHR_NONE, 1'b0},
    '{12'd400,  CHR_C, CHR_D,    1'b1},
    '{12'd500,  CHR_D, CHR_NONE, 1'b0},
    '{12'd900,  CHR_C, CHR_M,    1'b1},
    '{12'd1000, CHR_M, CHR_NONE, 1'b0}
  };

  // Largest symbol whose value does not exceed the remainder.
  function automatic sym_t pick_sym(input logic [YEAR_W-1:0] rem);
    sym_t best;
    best = SYM_TABLE[0];
    for (int i = 1; i < NUM_SYMS; i++) begin
      if (SYM_TABLE[i].value <= rem) begin
        best = SYM_TABLE[i];
      end
    end
    return best;
  endfunction

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic beat_last;
  } sts_t;

endpackage

// ===== rtl/roman_numeral_encoder_unit.sv =====
// Top level of the Roman numeral encoder: joins the controller and the datapath.
// Depends on rne_pkg, rne_ctrl and rne_dp.
//
//  Channel | Direction | Payload                                  | Marker
//  in_     | slave     | tdata[11:0] year                         | -
//  out_    | master    | tdata[7:0] letter, tuser[0] rejected     | tlast ends a run
//  cfg_    | write     | cfg_addr index, cfg_wdata[11:0] value    | -
//
// A year is taken, then one letter beat leaves per cycle while the output is not
// stalled: up to fifteen beats, one beat for a rejected year. The next year is
// taken in the cycle after the last beat has entered the output register. Reset is
// synchronous and active low. A stalled output holds the run where it stands.
module roman_numeral_encoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rne_pkg::IN_TDATA_W-1:0]      in_tdata,   // [11:0] year
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rne_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] letter
  output logic                                out_tuser,  // [0] rejected
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [rne_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [rne_pkg::YEAR_W-1:0]          cfg_wdata
);

  rne_pkg::cmd_t cmd;
  rne_pkg::sts_t sts;

  rne_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rne_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .year         (in_tdata[rne_pkg::YEAR_W-1:0]),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_letter   (out_tdata),
    .out_rejected (out_tuser),
    .out_last     (out_tlast)
  );

  a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == rne_pkg::CHR_NONE) && out_tlast)
    else $error("Reject beat carries a letter or lacks tlast.");

  a_letter_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata == rne_pkg::CHR_M) || (out_tdata == rne_pkg::CHR_D) ||
      (out_tdata == rne_pkg::CHR_C) || (out_tdata == rne_pkg::CHR_L) ||
      (out_tdata == rne_pkg::CHR_X) || (out_tdata == rne_pkg::CHR_V) ||
      (out_tdata == rne_pkg::CHR_I))
    else $error("Letter beat carries a code that is no numeral letter.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input still ready after a year was taken.");

endmodule

// ===== rtl/rne_ctrl.sv =====
// Controller state machine of the Roman numeral encoder.
// Depends on rne_pkg for the command and status types.
module rne_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rne_pkg::sts_t sts,
  output rne_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign cmd.load  = in_tvalid && in_tready;
  assign cmd.step  = (state_r == S_RUN) && sts.slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.step && sts.beat_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rne_dp.sv =====
// Datapath of the Roman numeral encoder: range registers, remainder, pending
// second letter and output register. Depends on rne_pkg.
module rne_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rne_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [rne_pkg::YEAR_W-1:0]          cfg_wdata,
  input  logic [rne_pkg::YEAR_W-1:0]          year,
  input  rne_pkg::cmd_t                       cmd,
  output rne_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rne_pkg::LETTER_W-1:0]        out_letter,
  output logic                                out_rejected,
  output logic                                out_last
);

  logic [rne_pkg::YEAR_W-1:0]   min_year_r;
  logic [rne_pkg::YEAR_W-1:0]   max_year_r;
  logic [rne_pkg::YEAR_W-1:0]   rem_r;
  logic [rne_pkg::YEAR_W-1:0]   rem_nxt;
  logic                         reject_r;
  logic                         pend_r;
  logic [rne_pkg::LETTER_W-1:0] pend_letter_r;
  logic                         out_valid_r;
  logic [rne_pkg::LETTER_W-1:0] letter_r;
  logic                         rejected_r;
  logic                         last_r;
  logic [rne_pkg::LETTER_W-1:0] letter_nxt;
  logic                         last_nxt;
  logic                         year_bad;
  rne_pkg::sym_t                sym;

  assign year_bad = (year < min_year_r) || (year > max_year_r) ||
                    (year == '0) || (year > rne_pkg::HARD_MAX_YEAR);

  assign sym = rne_pkg::pick_sym(rem_r);

  always_comb begin
    rem_nxt    = rem_r;
    letter_nxt = rne_pkg::CHR_NONE;
    last_nxt   = 1'b1;
    if (reject_r) begin
      letter_nxt = rne_pkg::CHR_NONE;
      last_nxt   = 1'b1;
    end else if (pend_r) begin
      letter_nxt = pend_letter_r;
      last_nxt   = (rem_r == '0);
    end else begin
      rem_nxt    = rem_r - sym.value;
      letter_nxt = sym.first;
      last_nxt   = !sym.pair && (rem_nxt == '0);
    end
  end

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.beat_last = last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r  <= rne_pkg::MIN_YEAR_RST;
      max_year_r  <= rne_pkg::MAX_YEAR_RST;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          rne_pkg::REG_MIN_YEAR: min_year_r <= cfg_wdata;
          rne_pkg::REG_MAX_YEAR: max_year_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        pend_r <= 1'b0;
      end else if (cmd.step) begin
        pend_r <= !reject_r && !pend_r && sym.pair;
      end
      if (cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r    <= year;
      reject_r <= year_bad;
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
    end
    if (cmd.step && !pend_r) begin
      pend_letter_r <= sym.second;
    end
    if (cmd.step) begin
      letter_r   <= letter_nxt;
      rejected_r <= reject_r;
      last_r     <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_letter   = letter_r;
  assign out_rejected = rejected_r;
  assign out_last     = last_r;

endmodule

// ===== sim/tb.sv =====
// Testbench for roman_numeral_encoder_unit: drives years into the stream input and checks
// every letter beat against a behavioural numeral predictor held in a scoreboard class.
// Depends on rne_pkg and the RTL of the encoder.
`timescale 1ns / 1ps

module tb;
  import rne_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 75;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                rejected;
    logic                last;
  } beat_t;

  class numeral_board;
    int    min_year;
    int    max_year;
    int    errors;
    beat_t pending_beats[$];
    beat_t run[$];

    function new();
      min_year = MIN_YEAR_RST;
      max_year = MAX_YEAR_RST;
      errors   = 0;
    endfunction

    function void push_letter(logic [LETTER_W-1:0] ch);
      beat_t b;
      b.letter   = ch;
      b.rejected = 1'b0;
      b.last     = 1'b0;
      run.push_back(b);
    endfunction

    function void push_digit(int d, logic [LETTER_W-1:0] one, logic [LETTER_W-1:0] five,
                             logic [LETTER_W-1:0] ten);
      int fives;
      int ones;
      fives = d / 5;
      ones  = d % 5;
      if (ones == 4) begin
        push_letter(one);
        push_letter(fives != 0 ? ten : five);
      end else begin
        if (fives != 0) begin
          push_letter(five);
        end
        for (int k = 0; k < ones; k++) begin
          push_letter(one);
        end
      end
    endfunction

    function void note_year(logic [YEAR_W-1:0] year);
      int    y;
      beat_t b;
      y = year;
      run.delete();
      if (y < min_year || y > max_year || y == 0 || y > HARD_MAX_YEAR) begin
        b.letter   = CHR_NONE;
        b.rejected = 1'b1;
        b.last     = 1'b1;
        run.push_back(b);
      end else begin
        for (int k = 0; k < y / 1000; k++) begin
          push_letter(CHR_M);
        end
        push_digit((y / 100) % 10, CHR_C, CHR_D, CHR_M);
        push_digit((y / 10) % 10, CHR_X, CHR_L, CHR_C);
        push_digit(y % 10, CHR_I, CHR_V, CHR_X);
        b = run[run.size() - 1];
        b.last = 1'b1;
        run[run.size() - 1] = b;
      end
      foreach (run[i]) begin
        pending_beats.push_back(run[i]);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: beat with nothing expected: letter %h rejected %b last %b",
                 $time, got.letter, got.rejected, got.last);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got.letter !== want.letter) begin
          $display("%0t: letter expected %h actual %h", $time, want.letter, got.letter);
          errors++;
        end
        if (got.rejected !== want.rejected) begin
          $display("%0t: rejected expected %b actual %b", $time, want.rejected, got.rejected);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_addr = '0;
  logic [YEAR_W-1:0]       cfg_wdata = '0;

  int          in_idle = 0;
  int          out_idle = 0;
  int          cycles = 0;
  numeral_board board = new();

  roman_numeral_encoder_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= out_idle);
  end

  always @(posedge clk) begin
    beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.letter   = out_tdata;
      got.rejected = out_tuser;
      got.last     = out_tlast;
      board.check_beat(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_year(input logic [YEAR_W-1:0] year);
    while ($urandom_range(99, 0) < in_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_TDATA_W - YEAR_W){1'b0}}, year};
    do begin
      @(posedge clk);
    end while (!in_tready);
    board.note_year(year);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained(input int hold);
    while (board.pending_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (hold) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MIN_YEAR) begin
      board.min_year = value;
    end else begin
      board.max_year = value;
    end
  endtask

  task automatic set_limits(input int lo, input int hi);
    wait_drained(4);
    write_reg(REG_MIN_YEAR, lo[YEAR_W-1:0]);
    write_reg(REG_MAX_YEAR, hi[YEAR_W-1:0]);
  endtask

  function automatic logic [YEAR_W-1:0] pick_year();
    int lo;
    int hi;
    int roll;
    lo   = (board.min_year < 1) ? 1 : board.min_year;
    hi   = (board.max_year > HARD_MAX_YEAR) ? HARD_MAX_YEAR : board.max_year;
    roll = $urandom_range(99, 0);
    if (roll < 70 && lo <= hi) begin
      return YEAR_W'($urandom_range(hi, lo));
    end else if (roll < 80) begin
      return (roll < 75) ? YEAR_W'(board.min_year) : YEAR_W'(board.max_year);
    end else if (roll < 85) begin
      return (roll < 83) ? YEAR_W'(board.min_year - 1) : YEAR_W'(board.max_year + 1);
    end
    return YEAR_W'($urandom_range(4095, 0));
  endfunction

  initial begin
    logic [YEAR_W-1:0] reset_years[4] = '{12'd999, 12'd1000, 12'd3000, 12'd3001};
    logic [YEAR_W-1:0] edge_years[20] = '{
      12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd14, 12'd40, 12'd49, 12'd90, 12'd400,
      12'd444, 12'd900, 12'd999, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2048,
      12'd1365, 12'd2730};
    int lo_tab[NUM_PHASES] = '{1, 1500, 3000, 0, 0, 2500};
    int hi_tab[NUM_PHASES] = '{3999, 1500, 100, 4095, 0, 4095};

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (reset_years[i]) begin
      send_year(reset_years[i]);
    end
    set_limits(0, 4095);
    foreach (edge_years[i]) begin
      send_year(edge_years[i]);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_idle  = (p < 2) ? 31 : (p < 4) ? 67 : 0;
      out_idle = (p < 2) ? 67 : (p < 4) ? 31 : 0;
      if (p == 4) begin
        lo_tab[p] = $urandom_range(2000, 1);
        hi_tab[p] = $urandom_range(3999, lo_tab[p]);
      end
      set_limits(lo_tab[p], hi_tab[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          wait_drained(0);
        end
        send_year(pick_year());
      end
    end

    wait_drained(20);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
